// ----- rtl/rlee_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the row-limited RLE encoder.
// Used by every module in rtl/; depends on nothing.
package rlee_pkg;

    localparam int TILE_W     = 8;
    localparam int LEN_W      = 11;
    localparam int POS_W      = 18;
    localparam int MAX_WIDTH  = 1024;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int M_TDATA_W  = 40;

    localparam logic [LEN_W-1:0] ROW_WIDTH_RESET = LEN_W'(64);
    localparam logic [LEN_W-1:0] WIDTH_CAP       = LEN_W'(MAX_WIDTH);

    typedef enum logic {
        KIND_PAIR = 1'b0,
        KIND_MARK = 1'b1
    } kind_t;

    // One accepted input item's worth of results, in compact form.
    typedef struct packed {
        logic              a_en;      // pair closed by a tile change
        logic [TILE_W-1:0] a_tile;
        logic [LEN_W-1:0]  a_len;
        logic [POS_W-1:0]  a_pos;
        logic              row_end;   // pair plus row mark
        logic              c_en;      // pair flushed by end of map
        logic [TILE_W-1:0] bc_tile;
        logic [LEN_W-1:0]  bc_len;
        logic [POS_W-1:0]  bc_pos;
    } cmd_t;

    typedef struct packed {
        kind_t             kind;
        logic [TILE_W-1:0] tile_code;
        logic [LEN_W-1:0]  run_length;
        logic [POS_W-1:0]  word_position;
        logic              last;
    } res_t;

endpackage

// ----- rtl/rlee_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts tiles, tracks runs, columns and word count,
// and pushes a command per tile that closes anything. Uses rlee_pkg.
module rlee_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [rlee_pkg::LEN_W-1:0]   cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rlee_pkg::TILE_W-1:0]  s_tile,
    input  logic                         s_tlast,
    input  logic                         q_full,
    output logic                         q_wr,
    output rlee_pkg::cmd_t               q_wr_data
);

    logic [rlee_pkg::LEN_W-1:0]  row_width_reg;
    logic [rlee_pkg::TILE_W-1:0] cur_tile_reg;
    logic [rlee_pkg::LEN_W-1:0]  open_run_reg, open_run_next;
    logic [rlee_pkg::LEN_W-1:0]  column_reg, column_next;
    logic [rlee_pkg::POS_W-1:0]  word_count_reg, word_count_next;

    logic [rlee_pkg::LEN_W-1:0]  eff_w;
    logic [rlee_pkg::LEN_W-1:0]  run1, col1;
    logic [rlee_pkg::POS_W-1:0]  a_pos, wc1, bc_pos;
    logic                        a_en, row_end, c_en, accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (row_width_reg == '0) begin
            eff_w = rlee_pkg::LEN_W'(1);
        end else if (row_width_reg > rlee_pkg::WIDTH_CAP) begin
            eff_w = rlee_pkg::WIDTH_CAP;
        end else begin
            eff_w = row_width_reg;
        end

        a_en    = (open_run_reg != '0) && (s_tile != cur_tile_reg);
        run1    = (a_en ? '0 : open_run_reg) + rlee_pkg::LEN_W'(1);
        col1    = column_reg + rlee_pkg::LEN_W'(1);
        row_end = (col1 >= eff_w);
        c_en    = s_tlast && !row_end && (run1 != '0);

        a_pos   = word_count_reg + rlee_pkg::POS_W'(2);
        wc1     = a_en ? a_pos : word_count_reg;
        bc_pos  = wc1 + rlee_pkg::POS_W'(2);

        open_run_next   = (row_end || s_tlast) ? '0 : run1;
        column_next     = (row_end || s_tlast) ? '0 : col1;
        word_count_next = s_tlast ? '0 : (row_end ? bc_pos : wc1);

        q_wr_data.a_en    = a_en;
        q_wr_data.a_tile  = cur_tile_reg;
        q_wr_data.a_len   = open_run_reg;
        q_wr_data.a_pos   = a_pos;
        q_wr_data.row_end = row_end;
        q_wr_data.c_en    = c_en;
        q_wr_data.bc_tile = s_tile;
        q_wr_data.bc_len  = run1;
        q_wr_data.bc_pos  = bc_pos;

        q_wr = accept && (a_en || row_end || c_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg  <= rlee_pkg::ROW_WIDTH_RESET;
            cur_tile_reg   <= '0;
            open_run_reg   <= '0;
            column_reg     <= '0;
            word_count_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                row_width_reg <= cfg_wr_data;
            end
            if (accept) begin
                cur_tile_reg   <= s_tile;
                open_run_reg   <= open_run_next;
                column_reg     <= column_next;
                word_count_reg <= word_count_next;
            end
        end
    end

endmodule

// ----- rtl/rlee_queue.sv -----
`timescale 1ns / 1ps
// Small first-word-fall-through command queue between front and back end.
// Uses rlee_pkg for the entry type and depth.
module rlee_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr,
    input  rlee_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd,
    output rlee_pkg::cmd_t rd_data,
    output logic           empty
);

    rlee_pkg::cmd_t                mem [rlee_pkg::QDEPTH];
    logic [rlee_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [rlee_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          do_wr, do_rd;

    assign full    = (count_reg == rlee_pkg::QCNT_W'(rlee_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + rlee_pkg::QCNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - rlee_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + rlee_pkg::QPTR_W'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + rlee_pkg::QPTR_W'(1);
            end
        end
    end

endmodule

// ----- rtl/rlee_back.sv -----
`timescale 1ns / 1ps
// Back end: expands each queued command into one to three result
// transactions through a registered output stage. Uses rlee_pkg.
module rlee_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  rlee_pkg::cmd_t q_rd_data,
    output logic           q_rd,
    output logic           m_tvalid,
    input  logic           m_tready,
    output rlee_pkg::res_t m_res
);

    logic           m_tvalid_reg;
    rlee_pkg::res_t res_reg, res_next;
    logic [1:0]     idx_reg, idx_next;
    logic [1:0]     n_res, k;
    logic           load;

    assign m_tvalid = m_tvalid_reg;
    assign m_res    = res_reg;

    always_comb begin
        n_res = {1'b0, q_rd_data.a_en}
              + (q_rd_data.row_end ? 2'd2 : {1'b0, q_rd_data.c_en});
        k     = idx_reg - {1'b0, q_rd_data.a_en};
        load  = !q_empty && (!m_tvalid_reg || m_tready);

        if (q_rd_data.a_en && idx_reg == 2'd0) begin
            res_next.kind          = rlee_pkg::KIND_PAIR;
            res_next.tile_code     = q_rd_data.a_tile;
            res_next.run_length    = q_rd_data.a_len;
        end else if (k == 2'd0) begin
            res_next.kind          = rlee_pkg::KIND_PAIR;
            res_next.tile_code     = q_rd_data.bc_tile;
            res_next.run_length    = q_rd_data.bc_len;
        end else begin
            res_next.kind          = rlee_pkg::KIND_MARK;
            res_next.tile_code     = '0;
            res_next.run_length    = '0;
        end
        res_next.word_position = (q_rd_data.a_en && idx_reg == 2'd0)
                               ? q_rd_data.a_pos : q_rd_data.bc_pos;
        res_next.last          = (idx_reg == n_res - 2'd1);

        q_rd     = load && res_next.last;
        idx_next = q_rd ? 2'd0 : (load ? idx_reg + 2'd1 : idx_reg);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            idx_reg      <= 2'd0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/row_limited_rle_encoder_top.sv -----
`timescale 1ns / 1ps
// Top level of the row-limited RLE encoder: front end, command queue, back end.
// Depends on rlee_pkg, rlee_front, rlee_queue and rlee_back.

// Takes one tile per cycle while the queue is not full. Each tile yields zero
// to three results (run pairs and a row-end mark); the front end packs them into
// one command in a four-entry queue and the back end sends them one transaction
// per cycle while m_tready is high, from a registered output. Sustained input
// rate is one tile per cycle as long as results average at most one per tile;
// the output port emits at most one result per cycle. A tile's first result
// goes through a queue entry and the output register. row_width 0 acts as 1,
// values above 1024 act as 1024; write it only while the block is idle.
module row_limited_rle_encoder_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rlee_pkg::LEN_W-1:0]          cfg_wr_data,   // row_width
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rlee_pkg::TILE_W-1:0]         s_tdata,       // tile
    input  logic                                s_tlast,       // end_of_map
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tile_code[7:0], run_length[18:8], word_position[36:19], zero fill
    output logic [rlee_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,       // kind
    output logic                                m_tlast        // last
);

    logic           q_wr, q_rd, q_full, q_empty;
    rlee_pkg::cmd_t q_wr_data, q_rd_data;
    rlee_pkg::res_t m_res;

    rlee_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tile      (s_tdata),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .q_wr        (q_wr),
        .q_wr_data   (q_wr_data)
    );

    rlee_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    rlee_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_rd_data (q_rd_data),
        .q_rd      (q_rd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {3'b000, m_res.word_position, m_res.run_length, m_res.tile_code};
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.last;

endmodule
